/* hw/rtl/bgc_pkg.sv */
package bgc_pkg;

    // Timestamp width; every time value wraps modulo 2**TIME_WIDTH.
    localparam int TIME_WIDTH = 32;

    // Click counter saturates here.
    localparam int CLICK_LIMIT = 255;
    localparam int CLICK_WIDTH = $clog2(CLICK_LIMIT + 1);

    // Configuration port geometry.
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_IDX_WIDTH  = 2;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_INITIAL_LEVEL = 2'd0,
        REG_DEBOUNCE_TIME = 2'd1,
        REG_DOUBLE_WINDOW = 2'd2,
        REG_LONG_TIME     = 2'd3
    } t_reg_idx;

    // Reset values of the configuration registers.
    localparam logic                      RST_INITIAL_LEVEL = 1'b0;
    localparam logic [CFG_DATA_WIDTH-1:0] RST_DEBOUNCE_TIME = 16'd20;
    localparam logic [CFG_DATA_WIDTH-1:0] RST_DOUBLE_WINDOW = 16'd300;
    localparam logic [CFG_DATA_WIDTH-1:0] RST_LONG_TIME     = 16'd800;

    // Reported gesture codes.
    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_SHORT  = 2'd1,
        GEST_DOUBLE = 2'd2,
        GEST_LONG   = 2'd3
    } t_gesture;

    typedef logic [TIME_WIDTH-1:0]  t_time;
    typedef logic [CLICK_WIDTH-1:0] t_click;

endpackage

/* hw/rtl/bgc_in_if.sv */
interface bgc_in_if;
    logic               valid;
    logic               ready;
    logic               raw_level;
    bgc_pkg::t_time     now_time;

    modport source (output valid, output raw_level, output now_time, input ready);
    modport sink   (input valid, input raw_level, input now_time, output ready);
endinterface

/* hw/rtl/bgc_out_if.sv */
interface bgc_out_if;
    logic               valid;
    logic               ready;
    bgc_pkg::t_gesture  gesture;

    modport source (output valid, output gesture, input ready);
    modport sink   (input valid, input gesture, output ready);
endinterface

/* hw/rtl/button_gesture_classifier.sv */
// Debounced button gesture classifier. Each input item carries a raw button level and a
// millisecond timestamp, and produces exactly one result item holding a gesture code
// (none, short, double or long press). The block takes one item per clock cycle: the whole
// classification is one pass of subtract-and-compare logic from the accepted item and the
// tracking registers into a single output register. The next item is accepted in the same
// cycle that the previous result is taken; while a result waits for the consumer, the input
// stalls. A result is valid in the cycle after its item is accepted. Thresholds are set
// through the write port: writing the initial level also reloads all tracking state, with
// timestamps counted from zero.
module button_gesture_classifier (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    bgc_in_if.sink                                i_in,
    bgc_out_if.source                             o_out,
    input  logic                                  i_cfg_we,
    input  logic [bgc_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_idx,
    input  logic [bgc_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data
);

    // Elapsed time since a mark, zero when the clock appears to run backwards.
    function automatic bgc_pkg::t_time since(bgc_pkg::t_time t_now, bgc_pkg::t_time t_mark);
        return (t_now >= t_mark) ? (t_now - t_mark) : '0;
    endfunction

    // Configuration registers.
    logic [bgc_pkg::CFG_DATA_WIDTH-1:0]   r_debounce_time;
    logic [bgc_pkg::CFG_DATA_WIDTH-1:0]   r_double_window;
    logic [bgc_pkg::CFG_DATA_WIDTH-1:0]   r_long_time;

    // Tracking state.
    logic               r_last_raw,        n_last_raw;
    bgc_pkg::t_time     r_raw_change_time, n_raw_change_time;
    logic               r_stable_level,    n_stable_level;
    bgc_pkg::t_time     r_press_time,      n_press_time;
    bgc_pkg::t_time     r_release_time,    n_release_time;
    logic               r_long_reported,   n_long_reported;
    bgc_pkg::t_click    r_click_count,     n_click_count;

    // Output register.
    logic               r_out_valid;
    bgc_pkg::t_gesture  r_gesture,         n_gesture;

    logic               in_accept;
    logic               raw_changed;
    logic               stable_changed;
    bgc_pkg::t_time     since_raw;
    bgc_pkg::t_time     since_press;
    bgc_pkg::t_time     since_release;
    logic               init_write;

    // Accept a new item whenever the output register is empty or being drained.
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.gesture = r_gesture;

    assign init_write = i_cfg_we && (i_cfg_idx == bgc_pkg::REG_INITIAL_LEVEL);

    // One classification pass: debounce, then long-press check, then click report.
    always_comb begin
        n_last_raw        = i_in.raw_level;
        n_raw_change_time = r_raw_change_time;
        n_stable_level    = r_stable_level;
        n_press_time      = r_press_time;
        n_release_time    = r_release_time;
        n_long_reported   = r_long_reported;
        n_click_count     = r_click_count;
        n_gesture         = bgc_pkg::GEST_NONE;

        raw_changed = (i_in.raw_level != r_last_raw);
        if (raw_changed) begin
            n_raw_change_time = i_in.now_time;
        end
        since_raw = raw_changed ? '0 : since(i_in.now_time, r_raw_change_time);

        stable_changed = (r_stable_level != i_in.raw_level) &&
                         (since_raw >= bgc_pkg::TIME_WIDTH'(r_debounce_time));
        if (stable_changed) begin
            n_stable_level = i_in.raw_level;
            if (i_in.raw_level) begin
                n_press_time    = i_in.now_time;
                n_long_reported = 1'b0;
            end else if (!r_long_reported) begin
                if (r_click_count < bgc_pkg::CLICK_WIDTH'(bgc_pkg::CLICK_LIMIT)) begin
                    n_click_count = r_click_count + bgc_pkg::CLICK_WIDTH'(1);
                end
                n_release_time = i_in.now_time;
            end
        end

        // A mark set by this very item has zero elapsed time.
        since_press   = (stable_changed && i_in.raw_level) ? '0 :
                        since(i_in.now_time, r_press_time);
        since_release = (stable_changed && !i_in.raw_level && !r_long_reported) ? '0 :
                        since(i_in.now_time, r_release_time);

        // Long press takes priority over the click report.
        if (n_stable_level && !n_long_reported &&
            (since_press >= bgc_pkg::TIME_WIDTH'(r_long_time))) begin
            n_long_reported = 1'b1;
            n_click_count   = '0;
            n_gesture       = bgc_pkg::GEST_LONG;
        end else if (!n_stable_level && (n_click_count != '0) &&
                     (since_release >= bgc_pkg::TIME_WIDTH'(r_double_window))) begin
            n_gesture     = (n_click_count >= bgc_pkg::CLICK_WIDTH'(2)) ?
                            bgc_pkg::GEST_DOUBLE : bgc_pkg::GEST_SHORT;
            n_click_count = '0;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time <= bgc_pkg::RST_DEBOUNCE_TIME;
            r_double_window <= bgc_pkg::RST_DOUBLE_WINDOW;
            r_long_time     <= bgc_pkg::RST_LONG_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                // The initial level only takes effect by reloading the tracking state.
                bgc_pkg::REG_INITIAL_LEVEL: ;
                bgc_pkg::REG_DEBOUNCE_TIME: r_debounce_time <= i_cfg_data;
                bgc_pkg::REG_DOUBLE_WINDOW: r_double_window <= i_cfg_data;
                bgc_pkg::REG_LONG_TIME:     r_long_time     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Tracking state: cleared by reset, reloaded by an initial-level write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw        <= bgc_pkg::RST_INITIAL_LEVEL;
            r_stable_level    <= bgc_pkg::RST_INITIAL_LEVEL;
            r_raw_change_time <= '0;
            r_press_time      <= '0;
            r_release_time    <= '0;
            r_long_reported   <= 1'b0;
            r_click_count     <= '0;
        end else if (init_write) begin
            r_last_raw        <= i_cfg_data[0];
            r_stable_level    <= i_cfg_data[0];
            r_raw_change_time <= '0;
            r_press_time      <= '0;
            r_release_time    <= '0;
            r_long_reported   <= 1'b0;
            r_click_count     <= '0;
        end else if (in_accept) begin
            r_last_raw        <= n_last_raw;
            r_stable_level    <= n_stable_level;
            r_raw_change_time <= n_raw_change_time;
            r_press_time      <= n_press_time;
            r_release_time    <= n_release_time;
            r_long_reported   <= n_long_reported;
            r_click_count     <= n_click_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_gesture <= n_gesture;
        end
    end

endmodule

/* hw/rtl/bgc_checker.sv */
module bgc_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  bgc_pkg::t_gesture    i_gesture
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // A stalled result keeps its gesture.
    a_gesture_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_gesture))
        else $error("gesture changed while stalled");

    // With a result stalled, no new item may enter.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while the output register is full");

    // Every accepted item yields a result in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted item produced no result");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_gesture   (o_out.gesture)
);
